@@ rtl/core/deq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Queue depth, index widths, operation and status codes, the result record
// and the ring index helper.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Queue storage
    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int DATA_W = 32;

    // Result buffer in front of the output port
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [2:0]               t_op;
    typedef logic [1:0]               t_status;
    typedef logic [OQ_CW-1:0]         t_oq_cnt;

    // Operation codes
    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_BACK  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_BACK   = 3'd3;
    localparam t_op OP_DUMP_FRONT = 3'd4;
    localparam t_op OP_DUMP_BACK  = 3'd5;

    // Status codes
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    // One result item
    typedef struct packed {
        t_status status;
        t_data   value;
        logic    last;
    } t_result;

    // Ring slot at base + off, both below DEPTH
    function automatic t_idx slot_add(t_idx base, t_idx off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/deq_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH_P = 16,
    parameter int WIDTH_P = 32,
    parameter int AW_P    = $clog2(DEPTH_P)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW_P-1:0]    i_waddr,
    input  logic [WIDTH_P-1:0] i_wdata,
    input  logic [AW_P-1:0]    i_raddr,
    output logic [WIDTH_P-1:0] o_rdata
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/core/deq_outq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// deq_outq: result buffer
// Small FIFO of result items that decouples the queue logic from a stalling
// receiver. The head entry drives the output port directly.
// ----------------------------------------------------------------------------
module deq_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  deq_pkg::t_result  i_item,
    output deq_pkg::t_oq_cnt  o_count,
    output logic              o_valid,
    output deq_pkg::t_result  o_item,
    input  logic              i_stall
);
    import deq_pkg::*;

    t_result          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_head, n_head;
    logic [OQ_AW-1:0] r_tail, n_tail;
    t_oq_cnt          r_count, n_count;
    logic             w_pop;

    assign w_pop = (r_count != '0) && !i_stall;

    // Pointer and fill count update
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (w_pop) begin
            n_head = (r_head == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_head + OQ_AW'(1);
        end
        if (i_push) begin
            n_tail = (r_tail == OQ_AW'(OQ_DEPTH - 1)) ? '0 : r_tail + OQ_AW'(1);
        end
        unique case ({i_push, w_pop})
            2'b10:   n_count = r_count + OQ_CW'(1);
            2'b01:   n_count = r_count - OQ_CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_item;
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_head];

endmodule
`default_nettype wire

@@ rtl/core/double_ended_queue_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue of signed 32-bit values
// Input channel (i_valid / o_stall) takes one operation per item: push front
// or back, pop front or back, dump front-first or back-first. Output channel
// (o_valid / i_stall) returns result items with status, value and last.
// Entries live in a ring buffer RAM with registered read data; front index
// and entry count sit in registers.
// The result of an item passes through the pending-result registers and the
// result buffer before it appears on the output.
// Push and pop items are taken back to back while the result buffer has
// room. A dump reads the stored entries in turn, bounded by the single RAM
// read port; no new item is taken until the dump is done.
// A four-item result buffer sits in front of the output. When the receiver
// stalls, that buffer fills and o_stall rises so no result is ever dropped.
// Reset (synchronous, active low) empties the queue and the result buffer;
// the RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input channel
    input  logic             i_valid,
    output logic             o_stall,
    input  deq_pkg::t_op     i_operation,
    input  deq_pkg::t_data   i_value,
    // Output channel
    output logic             o_valid,
    input  logic             i_stall,
    output deq_pkg::t_status o_status,
    output deq_pkg::t_data   o_value_res,
    output logic             o_last
);
    import deq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    // Control state
    logic    r_state, n_state;
    t_idx    r_front, n_front;
    t_cnt    r_count, n_count;
    t_idx    r_idx,   n_idx;
    logic    r_dir,   n_dir;

    // Result waiting on RAM read data
    logic    r_pend_vld,    n_pend_vld;
    t_status r_pend_status, n_pend_status;
    logic    r_pend_use,    n_pend_use;
    logic    r_pend_last,   n_pend_last;

    // RAM ports
    logic              w_we;
    t_idx              w_waddr;
    t_idx              w_raddr;
    logic [DATA_W-1:0] w_rdata;

    // Misc
    t_oq_cnt         w_oq_count;
    logic [OQ_CW:0]  w_occ;
    logic            w_room;
    logic            w_accept;
    logic            w_full;
    logic            w_empty;
    t_cnt            w_cnt_m1;
    t_cnt            w_back_off;
    t_idx            w_front_dec;
    t_idx            w_front_inc;
    t_idx            w_dump_off;
    logic            w_dump_last;
    t_result         w_item;
    t_result         w_out;

    // Room in the result buffer, counting the result in flight
    assign w_occ  = {1'b0, w_oq_count} + {{OQ_CW{1'b0}}, r_pend_vld};
    assign w_room = (w_occ < (OQ_CW + 1)'(OQ_DEPTH));

    assign o_stall  = !((r_state == ST_IDLE) && w_room);
    assign w_accept = i_valid && !o_stall;

    // Ring arithmetic
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_cnt_m1    = r_count - CNT_W'(1);
    assign w_front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - IDX_W'(1);
    assign w_front_inc = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + IDX_W'(1);
    assign w_back_off  = w_cnt_m1 - CNT_W'(r_idx);
    assign w_dump_off  = r_dir ? w_back_off[IDX_W-1:0] : r_idx;
    assign w_dump_last = (CNT_W'(r_idx) == w_cnt_m1);

    // Operation decode and sequencing
    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_count       = r_count;
        n_idx         = r_idx;
        n_dir         = r_dir;
        n_pend_vld    = 1'b0;
        n_pend_status = STAT_OK;
        n_pend_use    = 1'b0;
        n_pend_last   = 1'b1;
        w_we          = 1'b0;
        w_waddr       = slot_add(r_front, r_count[IDX_W-1:0]);
        w_raddr       = r_front;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_operation)
                        OP_PUSH_FRONT: begin
                            n_pend_vld = 1'b1;
                            if (w_full) begin
                                n_pend_status = STAT_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_front_dec;
                                n_front = w_front_dec;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            n_pend_vld = 1'b1;
                            if (w_full) begin
                                n_pend_status = STAT_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            n_pend_vld = 1'b1;
                            if (w_empty) begin
                                n_pend_status = STAT_EMPTY;
                            end else begin
                                w_raddr    = r_front;
                                n_pend_use = 1'b1;
                                n_front    = w_front_inc;
                                n_count    = w_cnt_m1;
                            end
                        end
                        OP_POP_BACK: begin
                            n_pend_vld = 1'b1;
                            if (w_empty) begin
                                n_pend_status = STAT_EMPTY;
                            end else begin
                                w_raddr    = slot_add(r_front, w_cnt_m1[IDX_W-1:0]);
                                n_pend_use = 1'b1;
                                n_count    = w_cnt_m1;
                            end
                        end
                        OP_DUMP_FRONT, OP_DUMP_BACK: begin
                            if (w_empty) begin
                                n_pend_vld    = 1'b1;
                                n_pend_status = STAT_EMPTY;
                            end else begin
                                n_state = ST_DUMP;
                                n_idx   = '0;
                                n_dir   = (i_operation == OP_DUMP_BACK);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DUMP: begin
                // One entry per cycle while the result buffer has room
                if (w_room) begin
                    w_raddr     = slot_add(r_front, w_dump_off);
                    n_pend_vld  = 1'b1;
                    n_pend_use  = 1'b1;
                    n_pend_last = w_dump_last;
                    if (w_dump_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_front    <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_dir      <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_front    <= n_front;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_dir      <= n_dir;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
        r_pend_use    <= n_pend_use;
        r_pend_last   <= n_pend_last;
    end

    // Entry storage
    deq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result assembly: value only where a stored entry was read
    always_comb begin
        w_item.status = r_pend_status;
        w_item.value  = r_pend_use ? t_data'(w_rdata) : '0;
        w_item.last   = r_pend_last;
    end

    deq_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_pend_vld),
        .i_item  (w_item),
        .o_count (w_oq_count),
        .o_valid (o_valid),
        .o_item  (w_out),
        .i_stall (i_stall)
    );

    assign o_status    = w_out.status;
    assign o_value_res = w_out.value;
    assign o_last      = w_out.last;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_dump_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> (r_count != '0) && (CNT_W'(r_idx) < r_count))
        else $error("dump index outside stored entries");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_vld |-> (w_oq_count < OQ_CW'(OQ_DEPTH)) || (o_valid && !i_stall))
        else $error("result buffer overflow");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full &&
         ((i_operation == OP_PUSH_FRONT) || (i_operation == OP_PUSH_BACK)))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not add an entry");

endmodule
`default_nettype wire
